>>> hdl/window_rms_mean_min_max_top_defines.svh
// Assertion macros shared by the windowed RMS / mean / min / max block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef WINDOW_RMS_MEAN_MIN_MAX_TOP_DEFINES_SVH
`define WINDOW_RMS_MEAN_MIN_MAX_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define WRMM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define WRMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/wrmm_pkg.sv
// Shared types and constants of the windowed RMS / mean / min / max block.
// No dependencies; used by every module of the block.
package wrmm_pkg;

    // Window and start values
    localparam int unsigned MAX_WINDOW = 255;
    localparam logic signed [15:0] MIN_START = 16'sd4096;
    localparam logic signed [15:0] MAX_START = 16'sd0;

    // Window queue between front and back
    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_DEPTH = 1 << Q_AW;

    // Back-end iteration widths
    localparam int unsigned DIV_W  = 47;   // square sum (39) shifted by 8
    localparam int unsigned RAD_W  = 40;   // quotient never exceeds 2^38
    localparam int unsigned ROOT_W = RAD_W / 2;
    localparam int unsigned REM_W  = ROOT_W + 3;
    localparam int unsigned CNT_W  = 6;

    // One finished window handed from front to back
    typedef struct packed {
        logic [38:0]        square_sum;
        logic signed [23:0] value_sum;
        logic signed [15:0] max_value;
        logic signed [15:0] min_value;
        logic [7:0]         sample_count;
        logic               dropped;
    } t_win;

    // One result beat
    typedef struct packed {
        logic               overflow;
        logic [7:0]         sample_count;
        logic signed [15:0] min_value;
        logic [14:0]        max_value;
        logic signed [19:0] mean_q4;
        logic [19:0]        rms_q4;
    } t_res;

    // Back-end sequencer
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_SQRT,
        BS_HOLD
    } t_bstate;

endpackage

>>> hdl/wrmm_front.sv
// Front end: takes sample beats, squares them and accumulates one window.
// Depends on wrmm_pkg; pushes closed windows into wrmm_queue.
module wrmm_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [15:0]        i_sample,
    input  logic                      i_last,
    input  logic [wrmm_pkg::Q_AW:0]   i_q_level,
    output logic                      o_push,
    output wrmm_pkg::t_win            o_push_win
);

    logic                r_s1_valid;
    logic signed [15:0]  r_s1_sample;
    logic                r_s1_last;
    logic [30:0]         r_s1_sq;
    logic signed [31:0]  w_sq;

    logic [38:0]         r_sq_sum, n_sq_sum, a_sq_sum;
    logic signed [23:0]  r_vsum, n_vsum, a_vsum;
    logic signed [15:0]  r_max, n_max, a_max;
    logic signed [15:0]  r_min, n_min, a_min;
    logic [7:0]          r_cnt, n_cnt, a_cnt;
    logic                r_drop, n_drop, a_drop;

    // Room for the item in flight plus this one
    assign o_ready = (i_q_level < (wrmm_pkg::Q_AW + 1)'(wrmm_pkg::Q_DEPTH - 1));
    assign w_sq    = i_sample * i_sample;

    // Stage 1: square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid && o_ready;
        end
        if (i_valid && o_ready) begin
            r_s1_sample <= i_sample;
            r_s1_last   <= i_last;
            r_s1_sq     <= w_sq[30:0];
        end
    end

    // Stage 2: accumulate, close window on the marked beat
    always_comb begin
        a_sq_sum = r_sq_sum;
        a_vsum   = r_vsum;
        a_max    = r_max;
        a_min    = r_min;
        a_cnt    = r_cnt;
        a_drop   = r_drop;
        o_push   = 1'b0;
        if (r_s1_valid) begin
            if (r_cnt < 8'(wrmm_pkg::MAX_WINDOW)) begin
                a_sq_sum = r_sq_sum + {8'd0, r_s1_sq};
                a_vsum   = r_vsum + {{8{r_s1_sample[15]}}, r_s1_sample};
                if (r_s1_sample > r_max) begin
                    a_max = r_s1_sample;
                end
                if (r_s1_sample < r_min) begin
                    a_min = r_s1_sample;
                end
                a_cnt = r_cnt + 8'd1;
            end else begin
                a_drop = 1'b1;
            end
            o_push = r_s1_last;
        end
        o_push_win.square_sum   = a_sq_sum;
        o_push_win.value_sum    = a_vsum;
        o_push_win.max_value    = a_max;
        o_push_win.min_value    = a_min;
        o_push_win.sample_count = a_cnt;
        o_push_win.dropped      = a_drop;
        n_sq_sum = a_sq_sum;
        n_vsum   = a_vsum;
        n_max    = a_max;
        n_min    = a_min;
        n_cnt    = a_cnt;
        n_drop   = a_drop;
        if (o_push) begin
            n_sq_sum = '0;
            n_vsum   = '0;
            n_max    = wrmm_pkg::MAX_START;
            n_min    = wrmm_pkg::MIN_START;
            n_cnt    = '0;
            n_drop   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_sum <= '0;
            r_vsum   <= '0;
            r_max    <= wrmm_pkg::MAX_START;
            r_min    <= wrmm_pkg::MIN_START;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
        end else begin
            r_sq_sum <= n_sq_sum;
            r_vsum   <= n_vsum;
            r_max    <= n_max;
            r_min    <= n_min;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
        end
    end

endmodule

>>> hdl/wrmm_queue.sv
// Short queue of closed windows between front and back end.
// Depends on wrmm_pkg and the assertion macro header.
`include "window_rms_mean_min_max_top_defines.svh"

module wrmm_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  wrmm_pkg::t_win            i_push_win,
    input  logic                      i_pop,
    output logic                      o_valid,
    output wrmm_pkg::t_win            o_win,
    output logic [wrmm_pkg::Q_AW:0]   o_level
);

    wrmm_pkg::t_win               r_mem [wrmm_pkg::Q_DEPTH];
    logic [wrmm_pkg::Q_AW-1:0]    r_wr;
    logic [wrmm_pkg::Q_AW-1:0]    r_rd;
    logic [wrmm_pkg::Q_AW:0]      r_level;

    assign o_valid = (r_level != '0);
    assign o_win   = r_mem[r_rd];
    assign o_level = r_level;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_win;
        end
    end

    `WRMM_ASSERT_NOW(a_no_push_full, r_level == (wrmm_pkg::Q_AW + 1)'(wrmm_pkg::Q_DEPTH), !i_push, "window pushed into full queue")
    `WRMM_ASSERT_NOW(a_no_pop_empty, r_level == '0, !i_pop, "window popped from empty queue")
    `WRMM_ASSERT_NEXT(a_level_up, i_push && !i_pop, r_level == $past(r_level) + 1'b1, "queue level did not grow on push")

endmodule

>>> hdl/wrmm_back.sv
// Back end: restoring division of both sums by the count, then bit-pair
// square root, then the result register. Depends on wrmm_pkg and the macro header.
`include "window_rms_mean_min_max_top_defines.svh"

module wrmm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  wrmm_pkg::t_win    i_q_win,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output wrmm_pkg::t_res    o_res
);

    wrmm_pkg::t_bstate                r_st, n_st;
    logic [wrmm_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    // Division: quotient shifts into the dividend register
    logic [wrmm_pkg::DIV_W-1:0]       r_qa, n_qa;
    logic [wrmm_pkg::DIV_W-1:0]       r_qb, n_qb;
    logic [7:0]                       r_ra, n_ra;
    logic [7:0]                       r_rb, n_rb;
    logic [8:0]                       w_ta, w_tb;
    logic                             w_ga, w_gb;

    // Square root
    logic [wrmm_pkg::RAD_W-1:0]       r_rad, n_rad;
    logic [wrmm_pkg::ROOT_W-1:0]      r_root, n_root;
    logic [wrmm_pkg::REM_W-1:0]       r_rem, n_rem;
    logic [wrmm_pkg::REM_W-1:0]       w_sr, w_trial;
    logic                             w_sge;

    // Window side data
    logic [7:0]                       r_n;
    logic                             r_neg;
    logic signed [15:0]               r_max, r_min;
    logic                             r_drop;
    logic [23:0]                      w_mag;

    // Result register
    logic                             r_o_valid, n_o_valid;
    wrmm_pkg::t_res                   r_res, n_res;
    logic                             w_load;

    assign o_valid = r_o_valid;
    assign o_res   = r_res;
    assign w_mag   = i_q_win.value_sum[23] ? 24'(-i_q_win.value_sum)
                                           : i_q_win.value_sum;

    // Division step for both dividends
    assign w_ta = {r_ra, r_qa[wrmm_pkg::DIV_W-1]};
    assign w_tb = {r_rb, r_qb[wrmm_pkg::DIV_W-1]};
    assign w_ga = (w_ta >= {1'b0, r_n});
    assign w_gb = (w_tb >= {1'b0, r_n});

    // Square root step: two radicand bits a cycle
    assign w_sr    = {r_rem[wrmm_pkg::REM_W-3:0], r_rad[wrmm_pkg::RAD_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_sge   = (w_sr >= w_trial);

    // Sequencer
    always_comb begin
        n_st      = r_st;
        n_cnt     = r_cnt;
        n_qa      = r_qa;
        n_qb      = r_qb;
        n_ra      = r_ra;
        n_rb      = r_rb;
        n_rad     = r_rad;
        n_root    = r_root;
        n_rem     = r_rem;
        o_q_pop   = 1'b0;
        w_load    = 1'b0;
        n_res     = r_res;
        case (r_st)
            wrmm_pkg::BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_qa    = {i_q_win.square_sum, 8'd0};
                    n_qb    = {19'd0, w_mag, 4'd0};
                    n_ra    = '0;
                    n_rb    = '0;
                    n_cnt   = '0;
                    n_st    = wrmm_pkg::BS_DIV;
                end
            end
            wrmm_pkg::BS_DIV: begin
                n_ra  = w_ga ? 8'(w_ta - {1'b0, r_n}) : w_ta[7:0];
                n_rb  = w_gb ? 8'(w_tb - {1'b0, r_n}) : w_tb[7:0];
                n_qa  = {r_qa[wrmm_pkg::DIV_W-2:0], w_ga};
                n_qb  = {r_qb[wrmm_pkg::DIV_W-2:0], w_gb};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == wrmm_pkg::CNT_W'(wrmm_pkg::DIV_W - 1)) begin
                    n_rad  = n_qa[wrmm_pkg::RAD_W-1:0];
                    n_root = '0;
                    n_rem  = '0;
                    n_cnt  = '0;
                    n_st   = wrmm_pkg::BS_SQRT;
                end
            end
            wrmm_pkg::BS_SQRT: begin
                n_rem  = w_sge ? (w_sr - w_trial) : w_sr;
                n_root = {r_root[wrmm_pkg::ROOT_W-2:0], w_sge};
                n_rad  = {r_rad[wrmm_pkg::RAD_W-3:0], 2'b00};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == wrmm_pkg::CNT_W'(wrmm_pkg::ROOT_W - 1)) begin
                    n_st = wrmm_pkg::BS_HOLD;
                end
            end
            wrmm_pkg::BS_HOLD: begin
                if (!r_o_valid || i_ready) begin
                    w_load             = 1'b1;
                    n_res.rms_q4       = r_root;
                    n_res.mean_q4      = r_neg ? -signed'(r_qb[19:0]) : signed'(r_qb[19:0]);
                    n_res.max_value    = r_max[14:0];
                    n_res.min_value    = r_min;
                    n_res.sample_count = r_n;
                    n_res.overflow     = r_drop;
                    n_st               = wrmm_pkg::BS_IDLE;
                end
            end
            default: begin
                n_st = wrmm_pkg::BS_IDLE;
            end
        endcase
        n_o_valid = w_load ? 1'b1 : (r_o_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= wrmm_pkg::BS_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_o_valid <= n_o_valid;
        end
        r_cnt  <= n_cnt;
        r_qa   <= n_qa;
        r_qb   <= n_qb;
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_rad  <= n_rad;
        r_root <= n_root;
        r_rem  <= n_rem;
        r_res  <= n_res;
        if (o_q_pop) begin
            r_n    <= i_q_win.sample_count;
            r_neg  <= i_q_win.value_sum[23];
            r_max  <= i_q_win.max_value;
            r_min  <= i_q_win.min_value;
            r_drop <= i_q_win.dropped;
        end
    end

    `WRMM_ASSERT_NEXT(a_start_div, r_st == wrmm_pkg::BS_IDLE && i_q_valid, r_st == wrmm_pkg::BS_DIV, "window taken but division not started")
    `WRMM_ASSERT_NEXT(a_div_to_sqrt, r_st == wrmm_pkg::BS_DIV && r_cnt == wrmm_pkg::CNT_W'(wrmm_pkg::DIV_W - 1), r_st == wrmm_pkg::BS_SQRT, "division did not hand over to square root")
    `WRMM_ASSERT_NOW(a_pop_idle, o_q_pop, r_st == wrmm_pkg::BS_IDLE, "window taken while busy")

endmodule

>>> hdl/window_rms_mean_min_max_top.sv
// Top level of the windowed RMS / mean / min / max block.
// Depends on wrmm_pkg, wrmm_front, wrmm_queue and wrmm_back.
//
//  channel   dir   beat contents (lowest bit first)
//  s_axis    in    tdata: sample[15:0]; tlast: last_sample
//  m_axis    out   tdata: rms_q4, mean_q4, max_value, min_value, sample_count, overflow
//
// The front end takes one sample beat a cycle while s_axis_tready is high; the square
// is registered before it is summed. For each window the back end runs the one-bit-a-cycle
// divider, then the bit-pair square root, loads the result, then takes the next window.
// Up to four closed windows wait in the queue; s_axis_tready falls when three are held.
// Reset is synchronous, active low, and empties the pipeline, queue and result register.
// A result waiting on m_axis_tready holds the back end in its last step only.
module window_rms_mean_min_max_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [19:0] rms_q4, [39:20] mean_q4, [54:40] max_value,
                                        // [70:55] min_value, [78:71] sample_count, [79] overflow
);

    logic                            w_push;
    wrmm_pkg::t_win                  w_push_win;
    logic                            w_pop;
    logic                            w_q_valid;
    wrmm_pkg::t_win                  w_q_win;
    logic [wrmm_pkg::Q_AW:0]         w_q_level;
    wrmm_pkg::t_res                  w_res;

    wrmm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_sample   (signed'(s_axis_tdata)),
        .i_last     (s_axis_tlast),
        .i_q_level  (w_q_level),
        .o_push     (w_push),
        .o_push_win (w_push_win)
    );

    wrmm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_win (w_push_win),
        .i_pop      (w_pop),
        .o_valid    (w_q_valid),
        .o_win      (w_q_win),
        .o_level    (w_q_level)
    );

    wrmm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_win    (w_q_win),
        .o_q_pop    (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (w_res)
    );

    // Result struct is laid out lowest field last, matching the beat packing
    assign m_axis_tdata = w_res;

endmodule

>>> verif/window_rms_mean_min_max_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for window_rms_mean_min_max_top: sample windows in, one summary beat out.
// Depends on wrmm_pkg and the block's RTL; predicts every result beat and checks it field by field.
module window_rms_mean_min_max_top_test;

    localparam int QUIET_LIMIT  = 4000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 150;    // cycles waited after the last predicted result has arrived
    localparam int PRESSURE_LEN = 800;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [15:0] sample
    logic        s_axis_tlast;    // last_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;    // rms_q4, mean_q4, max_value, min_value, sample_count, overflow

    // Predicted window statistics
    logic [38:0]        acc_sq;
    logic signed [23:0] acc_sum;
    logic signed [15:0] acc_hi;
    logic signed [15:0] acc_lo;
    logic [7:0]         acc_n;
    logic               acc_dropped;

    wrmm_pkg::t_res window_results_due[$];
    int   err_count;
    int   quiet_cycles;
    int   sink_hold_len;
    bit   send_calm;
    bit   sink_calm;

    window_rms_mean_min_max_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Floor square root by setting result bits from the top down
    function automatic logic [19:0] floor_root(input logic [46:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= {17'd0, v})
                root = trial;
        end
        return root[19:0];
    endfunction

    task automatic clear_window();
        acc_sq      = '0;
        acc_sum     = '0;
        acc_hi      = wrmm_pkg::MAX_START;
        acc_lo      = wrmm_pkg::MIN_START;
        acc_n       = '0;
        acc_dropped = 1'b0;
    endtask

    // Fold one accepted sample into the prediction; close the window on tlast
    task automatic fold_sample(input logic signed [15:0] smp, input logic lst);
        wrmm_pkg::t_res res;
        longint      sq;
        logic [46:0] quot;
        longint      mean_full;
        if (acc_n < wrmm_pkg::MAX_WINDOW) begin
            sq      = longint'(smp) * longint'(smp);
            acc_sq  = acc_sq + sq[38:0];
            acc_sum = acc_sum + smp;
            if (smp > acc_hi) acc_hi = smp;
            if (smp < acc_lo) acc_lo = smp;
            acc_n   = acc_n + 8'd1;
        end else begin
            acc_dropped = 1'b1;
        end
        if (lst) begin
            quot      = {acc_sq, 8'd0} / {39'd0, acc_n};
            // signed division truncates toward zero
            mean_full = (longint'(acc_sum) * 16) / longint'(acc_n);
            res.rms_q4       = floor_root(quot);
            res.mean_q4      = mean_full[19:0];
            res.max_value    = acc_hi[14:0];
            res.min_value    = acc_lo;
            res.sample_count = acc_n;
            res.overflow     = acc_dropped;
            window_results_due.push_back(res);
            clear_window();
        end
    endtask

    // Offer one sample beat, with a random gap first, and wait for it to go in
    task automatic push_sample(input logic signed [15:0] smp, input logic lst);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (send_calm || r < 65)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(15, 50);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        fold_sample(smp, lst);
    endtask

    function automatic logic [15:0] rand_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 5))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = 0;
                3:       v = -1;
                4:       v = 4096;
                default: v = 4097;
            endcase
        end else if (r < 40) begin
            v = int'($urandom_range(0, 10000)) - 5000;
        end else begin
            v = int'($urandom());
        end
        return v[15:0];
    endfunction

    // Single-sample windows at the field limits and around the start values,
    // then short windows, most of them with means that need truncation toward zero
    task automatic test_directed();
        push_sample(-16'sd32768, 1'b1);
        push_sample(16'sd32767, 1'b1);
        push_sample(16'sd0, 1'b1);
        push_sample(-16'sd1, 1'b1);
        push_sample(16'sd4095, 1'b1);
        push_sample(16'sd4096, 1'b1);
        push_sample(16'sd4097, 1'b1);
        push_sample(-16'sd1, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(-16'sd32768, 1'b0);
        push_sample(16'sd32767, 1'b1);
        push_sample(16'sd3, 1'b0);
        push_sample(-16'sd7, 1'b0);
        push_sample(16'sd2, 1'b1);
    endtask

    // Full window closed on its last accepted sample, then one where several
    // samples, the marked one among them, are dropped
    task automatic test_window_full();
        send_calm = 1'b1;
        for (int k = 1; k <= wrmm_pkg::MAX_WINDOW; k++)
            push_sample(-16'sd32768, k == wrmm_pkg::MAX_WINDOW);
        for (int k = 1; k <= wrmm_pkg::MAX_WINDOW + 3; k++)
            push_sample(16'sd32767, k == wrmm_pkg::MAX_WINDOW + 3);
        send_calm = 1'b0;
        // flag must be clear again in the next window
        push_sample(16'sd5, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering closed windows
    task automatic test_back_pressure();
        send_calm     = 1'b1;
        sink_hold_len = PRESSURE_LEN;
        for (int k = 0; k < 12; k++)
            push_sample(rand_sample(), 1'b1);
        send_calm = 1'b0;
    endtask

    // Random short windows
    task automatic test_random_windows();
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < 60) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(9, 20);
            send_calm = ($urandom_range(0, 4) == 0);
            for (int k = 1; k <= len; k++)
                push_sample(rand_sample(), k == len);
            sent += len;
        end
        send_calm = 1'b0;
    endtask

    // Receiver: random stalls, calm stretches, and a long hold-off on request
    initial begin : sink_drive
        int stall;
        int phase;
        m_axis_tready = 1'b0;
        stall     = 0;
        phase     = 0;
        sink_calm = 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (phase % 256 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            if (sink_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_len) @(posedge i_clk);
                sink_hold_len = 0;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!sink_calm) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: stall = 0;
                        6, 7, 8:          stall = $urandom_range(1, 3);
                        default:          stall = $urandom_range(10, 40);
                    endcase
                end
            end
        end
    end

    task automatic check_field(input string label, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
            err_count++;
        end
    endtask

    // Compare each result beat with the oldest predicted window
    always @(posedge i_clk) begin : result_check
        wrmm_pkg::t_res got;
        wrmm_pkg::t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = wrmm_pkg::t_res'(m_axis_tdata);
            if (window_results_due.size() == 0) begin
                $display("%0t: result beat with no window pending, expected none, actual %h",
                         $time, m_axis_tdata);
                err_count++;
            end else begin
                want = window_results_due.pop_front();
                check_field("rms_q4", want.rms_q4, got.rms_q4);
                check_field("mean_q4", want.mean_q4, got.mean_q4);
                check_field("max_value", want.max_value, got.max_value);
                check_field("min_value", want.min_value, got.min_value);
                check_field("sample_count", want.sample_count, got.sample_count);
                check_field("overflow", want.overflow, got.overflow);
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Reset, tests in turn, drain and verdict
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        err_count     = 0;
        quiet_cycles  = 0;
        sink_hold_len = 0;
        send_calm     = 1'b0;
        clear_window();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_window_full();
        test_back_pressure();
        test_random_windows();

        s_axis_tvalid <= 1'b0;
        while (window_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && window_results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
